@@ hw/rtl/sltc_pkg.sv @@
// Shared types, codes and character classes for the script lexer token classifier.
package sltc_pkg;

	localparam int ROW_W = 16;
	localparam int LEN_W = 7;
	localparam int OFS_W = 32;
	localparam int KIND_W = 3;

	// Token kind codes as they appear on the result channel.
	localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CHAR_BANG = 8'h21;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_LOWER_S = 8'h73;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_COMMENT
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [ROW_W-1:0]  token_row;
		logic [ROW_W-1:0]  token_col;
		logic [LEN_W-1:0]  token_length;
		logic              length_clipped;
		logic [OFS_W-1:0]  token_offset;
		logic              last_of_run;
	} token_t;

	// Tokens produced by one byte, in order, handed from the scanner to the queue.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_symbol(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		unique case (b)
			8'h40, 8'h2B, 8'h3D, 8'h21, 8'h23, 8'h24,
			8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Expected characters of the keyword "scalar" by position.
	function automatic logic [7:0] scalar_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h73;
			3'd1: c = 8'h63;
			3'd2: c = 8'h61;
			3'd3: c = 8'h6C;
			3'd4: c = 8'h61;
			3'd5: c = 8'h72;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Expected characters of the keyword "foreach" by position.
	function automatic logic [7:0] foreach_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h66;
			3'd1: c = 8'h6F;
			3'd2: c = 8'h72;
			3'd3: c = 8'h65;
			3'd4: c = 8'h61;
			3'd5: c = 8'h63;
			3'd6: c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/sltc_scan.sv @@
// Scanner state and per-byte classification producing up to two tokens.
module sltc_scan import sltc_pkg::*; #(
	parameter int MAX_LEXEME = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  item_t item,
	output push_t push
);

	localparam int CNT_W = $clog2(MAX_LEXEME + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEXEME);
	localparam logic [CNT_W-1:0] CNT_SCALAR = CNT_W'(6);
	localparam logic [CNT_W-1:0] CNT_FOREACH = CNT_W'(7);

	scan_mode_t       mode_q, mode_d;
	logic [ROW_W-1:0] line_q, line_d;
	logic [ROW_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] start_row_q, start_row_d;
	logic [ROW_W-1:0] start_col_q, start_col_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       km_q, km_d;
	logic [OFS_W-1:0] pos_q, pos_d;
	logic [OFS_W-1:0] start_pos_q, start_pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= ROW_W'(1);
			col_q <= ROW_W'(1);
			start_row_q <= '0;
			start_col_q <= '0;
			cnt_q <= '0;
			km_q <= '0;
			pos_q <= '0;
			start_pos_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q <= col_d;
			start_row_q <= start_row_d;
			start_col_q <= start_col_d;
			cnt_q <= cnt_d;
			km_q <= km_d;
			pos_q <= pos_d;
			start_pos_q <= start_pos_d;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic       flush;
		logic       idle_go;
		logic       single_v;
		logic       word_char;
		token_t     flush_tok;
		token_t     single_tok;

		b = item.text_byte;
		flush = 1'b0;
		idle_go = 1'b0;
		single_v = 1'b0;
		word_char = is_letter(b) || is_digit(b);

		mode_d = mode_q;
		line_d = line_q;
		col_d = col_q;
		start_row_d = start_row_q;
		start_col_d = start_col_q;
		cnt_d = cnt_q;
		km_d = km_q;
		pos_d = pos_q;
		start_pos_d = start_pos_q;

		if (item.end_of_text) begin
			flush = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
			mode_d = MODE_IDLE;
		end else begin
			pos_d = pos_q + 1'b1;
			unique case (mode_q)
				MODE_COMMENT: begin
					if (b == CHAR_NEWLINE) begin
						line_d = sat_inc(line_q);
						col_d = ROW_W'(1);
						mode_d = MODE_IDLE;
					end else begin
						col_d = sat_inc(col_q);
					end
				end
				MODE_IDENT, MODE_NUMBER: begin
					if ((mode_q == MODE_IDENT && (word_char || b == CHAR_UNDERSCORE)) ||
					    (mode_q == MODE_NUMBER && is_digit(b))) begin
						if (cnt_q >= CNT_SCALAR || scalar_char(cnt_q[2:0]) != b)
							km_d[0] = 1'b0;
						if (cnt_q >= CNT_FOREACH || foreach_char(cnt_q[2:0]) != b)
							km_d[1] = 1'b0;
						if (cnt_q <= CNT_MAX)
							cnt_d = cnt_q + 1'b1;
						col_d = sat_inc(col_q);
					end else begin
						// The terminating byte is then scanned as if the scanner were idle.
						flush = 1'b1;
						idle_go = 1'b1;
						mode_d = MODE_IDLE;
					end
				end
				MODE_IDLE: idle_go = 1'b1;
				default: idle_go = 1'b1;
			endcase

			if (idle_go) begin
				if (b == CHAR_BANG) begin
					mode_d = MODE_COMMENT;
				end else if (is_symbol(b) || !(word_char || is_space(b))) begin
					single_v = 1'b1;
				end else if (word_char) begin
					mode_d = is_letter(b) ? MODE_IDENT : MODE_NUMBER;
					start_row_d = line_q;
					start_col_d = col_q;
					start_pos_d = pos_q;
					cnt_d = CNT_W'(1);
					km_d = {b == CHAR_LOWER_F, b == CHAR_LOWER_S};
				end
				if (b == CHAR_NEWLINE) begin
					line_d = sat_inc(line_q);
					col_d = ROW_W'(1);
				end else begin
					col_d = sat_inc(col_q);
				end
			end
		end

		flush_tok.token_kind = KIND_NUMBER;
		if (mode_q == MODE_IDENT) begin
			flush_tok.token_kind = ((cnt_q == CNT_SCALAR && km_q[0]) ||
			                        (cnt_q == CNT_FOREACH && km_q[1])) ? KIND_KEYWORD
			                                                           : KIND_IDENT;
		end
		flush_tok.token_row = start_row_q;
		flush_tok.token_col = start_col_q;
		flush_tok.token_length = LEN_W'((cnt_q > CNT_MAX) ? CNT_MAX : cnt_q);
		flush_tok.length_clipped = cnt_q > CNT_MAX;
		flush_tok.token_offset = start_pos_q;
		flush_tok.last_of_run = !single_v;

		single_tok.token_kind = is_symbol(b) ? KIND_SYMBOL : KIND_UNKNOWN;
		single_tok.token_row = line_q;
		single_tok.token_col = col_q;
		single_tok.token_length = LEN_W'(1);
		single_tok.length_clipped = 1'b0;
		single_tok.token_offset = pos_q;
		single_tok.last_of_run = 1'b1;

		push.count = 2'(flush) + 2'(single_v);
		push.first = flush ? flush_tok : single_tok;
		push.second = single_tok;
	end

endmodule

@@ hw/rtl/sltc_token_fifo.sv @@
// Small token queue that takes up to two tokens per cycle and releases one unless stalled.
module sltc_token_fifo import sltc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_en,
	input  push_t  push,
	output logic   room,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t token
);

	token_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]       rd_ptr_q;
	logic [FIFO_AW-1:0]       wr_ptr_q;
	logic [FIFO_AW:0]         count_q;
	logic [1:0]               wr_n;
	logic                     pop;
	logic [FIFO_AW-1:0]       wr_ptr_next;

	assign wr_n = push_en ? push.count : 2'd0;
	assign pop = token_valid && !token_stall;
	assign wr_ptr_next = wr_ptr_q + 1'b1;
	assign room = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign token_valid = count_q != '0;
	assign token = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(wr_n);
			count_q <= count_q + (FIFO_AW + 1)'(wr_n) - (FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (wr_n == 2'd2)
			mem_q[wr_ptr_next] <= push.second;
	end

endmodule

@@ hw/rtl/script_lexer_token_classifier_unit.sv @@
// Top level of the script lexer token classifier: input register, scanner and token queue.
//
// The unit takes one text byte per cycle and emits tokens (symbol, keyword, identifier,
// number, unknown) with start row, column, byte offset and length. A byte enters an input
// register, from which the scanner classifies it against the held scanner state once the
// queue has space for two tokens, and writes zero, one or two tokens into a four-entry token
// queue. A byte is taken every cycle as long as the queue has space for two tokens; the
// result side drains one token per cycle unless stalled, so byte throughput is one per cycle
// while at most one token per byte comes out and is bounded by the single output port when
// bytes produce two tokens. MAX_LEXEME sets where lexeme lengths saturate.
module script_lexer_token_classifier_unit import sltc_pkg::*; #(
	parameter int MAX_LEXEME = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  item_t  item,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t token
);

	item_t item_s1;
	logic  valid_s1;
	logic  room;
	logic  advance;
	logic  accept;
	push_t push;

	// The held byte is scanned once the queue can absorb both of its possible tokens.
	assign advance = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	sltc_scan #(
		.MAX_LEXEME(MAX_LEXEME)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.push   (push)
	);

	sltc_token_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (advance),
		.push       (push),
		.room       (room),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token      (token)
	);

endmodule

@@ tb/script_lexer_token_classifier_unit_tb.sv @@
// Self-checking testbench for the script lexer token classifier with its own token predictor.
module script_lexer_token_classifier_unit_tb import sltc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 64;
	localparam int RANDOM_ITEMS = 1650;
	localparam int unsigned CYCLE_LIMIT = 50_000;

	// Predicts the tokens of every accepted byte and matches them against the result channel.
	class lexer_tracker;
		scan_mode_t  mode;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic [15:0] start_line;
		logic [15:0] start_col;
		logic [6:0]  lex_len;
		logic [1:0]  kw_live;
		logic [31:0] byte_pos;
		logic [31:0] start_pos;
		token_t      awaited_tokens[$];
		token_t      step_tokens[$];
		int          errors;

		function new();
			mode = MODE_IDLE;
			line_no = 16'd1;
			col_no = 16'd1;
			start_line = '0;
			start_col = '0;
			lex_len = '0;
			kw_live = '0;
			byte_pos = '0;
			start_pos = '0;
			errors = 0;
		endfunction

		function logic [15:0] count_up16(input logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic alpha_char(input logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function logic digit_char(input logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function logic blank_char(input logic [7:0] b);
			return b == " " || (b >= 8'd9 && b <= 8'd13);
		endfunction

		function logic symbol_char(input logic [7:0] b);
			string syms;
			syms = "@+=!#$%^&*()";
			for (int i = 0; i < syms.len(); i++) begin
				if (syms[i] == b)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void push_token(input logic [KIND_W-1:0] kind, input logic [15:0] row,
				input logic [15:0] col, input logic [6:0] len, input logic clip,
				input logic [31:0] off);
			token_t t;
			t.token_kind = kind;
			t.token_row = row;
			t.token_col = col;
			t.token_length = len;
			t.length_clipped = clip;
			t.token_offset = off;
			t.last_of_run = 1'b0;
			step_tokens.push_back(t);
		endfunction

		function void flush_lexeme();
			logic [KIND_W-1:0] kind;
			logic is_kw;
			kind = KIND_NUMBER;
			if (mode == MODE_IDENT) begin
				is_kw = (lex_len == 7'd6 && kw_live[0]) || (lex_len == 7'd7 && kw_live[1]);
				kind = is_kw ? KIND_KEYWORD : KIND_IDENT;
			end
			push_token(kind, start_line, start_col, (lex_len > MAX_LEN) ? 7'(MAX_LEN) : lex_len,
				lex_len > MAX_LEN, start_pos);
			mode = MODE_IDLE;
		endfunction

		// A byte seen with no lexeme open; '!' opens a comment although it is in the symbol set.
		function void fresh_byte(input logic [7:0] b);
			if (b == "!") begin
				mode = MODE_COMMENT;
			end else if (symbol_char(b) || !(alpha_char(b) || digit_char(b) || blank_char(b))) begin
				push_token(symbol_char(b) ? KIND_SYMBOL : KIND_UNKNOWN, line_no, col_no, 7'd1,
					1'b0, byte_pos);
			end else if (alpha_char(b) || digit_char(b)) begin
				mode = alpha_char(b) ? MODE_IDENT : MODE_NUMBER;
				start_line = line_no;
				start_col = col_no;
				start_pos = byte_pos;
				lex_len = 7'd1;
				kw_live = {b == "f", b == "s"};
			end
			if (b == "\n") begin
				line_no = count_up16(line_no);
				col_no = 16'd1;
			end else begin
				col_no = count_up16(col_no);
			end
		endfunction

		function void extend_lexeme(input logic [7:0] b);
			string first_kw;
			string second_kw;
			first_kw = "scalar";
			second_kw = "foreach";
			if (lex_len >= 7'd6 || first_kw[lex_len] != b)
				kw_live[0] = 1'b0;
			if (lex_len >= 7'd7 || second_kw[lex_len] != b)
				kw_live[1] = 1'b0;
			if (lex_len <= MAX_LEN)
				lex_len = lex_len + 7'd1;
			col_no = count_up16(col_no);
		endfunction

		function void scan_byte(input item_t it);
			logic [7:0] b;
			token_t t;
			b = it.text_byte;
			step_tokens.delete();
			if (it.end_of_text) begin
				if (mode == MODE_IDENT || mode == MODE_NUMBER)
					flush_lexeme();
				mode = MODE_IDLE;
			end else begin
				case (mode)
					MODE_COMMENT: begin
						if (b == "\n") begin
							line_no = count_up16(line_no);
							col_no = 16'd1;
							mode = MODE_IDLE;
						end else begin
							col_no = count_up16(col_no);
						end
					end
					MODE_IDENT: begin
						if (alpha_char(b) || digit_char(b) || b == "_") begin
							extend_lexeme(b);
						end else begin
							flush_lexeme();
							fresh_byte(b);
						end
					end
					MODE_NUMBER: begin
						if (digit_char(b)) begin
							extend_lexeme(b);
						end else begin
							flush_lexeme();
							fresh_byte(b);
						end
					end
					default: fresh_byte(b);
				endcase
				byte_pos = byte_pos + 32'd1;
			end
			if (step_tokens.size() > 0) begin
				t = step_tokens.pop_back();
				t.last_of_run = 1'b1;
				step_tokens.push_back(t);
			end
			foreach (step_tokens[i])
				awaited_tokens.push_back(step_tokens[i]);
		endfunction

		function void compare_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void match_token(input token_t got);
			token_t want;
			if (awaited_tokens.size() == 0) begin
				$error("token with nothing pending: kind %0d, offset %0d", got.token_kind,
					got.token_offset);
				errors++;
				return;
			end
			want = awaited_tokens.pop_front();
			compare_field("token_kind", want.token_kind, got.token_kind);
			compare_field("token_row", want.token_row, got.token_row);
			compare_field("token_col", want.token_col, got.token_col);
			compare_field("token_length", want.token_length, got.token_length);
			compare_field("length_clipped", want.length_clipped, got.length_clipped);
			compare_field("token_offset", want.token_offset, got.token_offset);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   item_valid = 1'b0;
	logic   item_stall;
	item_t  item = '0;
	logic   token_valid;
	logic   token_stall = 1'b0;
	token_t token;

	lexer_tracker tracker;
	int unsigned  cycle_count = 0;
	int           items_sent = 0;
	logic         calm_tx;
	logic         calm_rx;

	script_lexer_token_classifier_unit #(.MAX_LEXEME(MAX_LEN)) i_dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.token_valid,
		.token_stall,
		.token
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stretches with no idling on either side.
	assign calm_tx = items_sent >= 800 && items_sent < 1100;
	assign calm_rx = cycle_count >= 1000 && cycle_count < 1400;

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			tracker.scan_byte(item);
		if (arst_n && token_valid && !token_stall)
			tracker.match_token(token);
		token_stall <= !calm_rx && ($urandom_range(99) < 20);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("script_lexer_token_classifier_unit test failed");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eot);
		item_t it;
		while (!calm_tx && $urandom_range(99) < 20) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		it.text_byte = b;
		it.end_of_text = eot;
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	function automatic int lexeme_size();
		return ($urandom_range(99) < 5) ? $urandom_range(60, 140) : $urandom_range(1, 10);
	endfunction

	function automatic logic [7:0] any_letter();
		return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
	endfunction

	// Mostly well-formed phrases that abut each other, so terminating bytes often make
	// two tokens; the rest is raw noise and end-of-text marks.
	task automatic send_random_text();
		int pick;
		int len;
		string syms;
		string words[8];
		logic [7:0] b;
		syms = "@+=#$%^&*()";
		words = '{"scalar", "foreach", "scala", "scalars", "foreac", "foreachx", "Scalar",
			"forEach"};
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				len = lexeme_size();
				send_item(any_letter(), 1'b0);
				for (int i = 1; i < len; i++) begin
					case ($urandom_range(3))
						0, 1: b = any_letter();
						2: b = 8'("0" + $urandom_range(9));
						default: b = "_";
					endcase
					send_item(b, 1'b0);
				end
			end else if (pick < 40) begin
				send_text(words[$urandom_range(7)]);
			end else if (pick < 55) begin
				len = lexeme_size();
				for (int i = 0; i < len; i++)
					send_item(8'("0" + $urandom_range(9)), 1'b0);
			end else if (pick < 67) begin
				send_item(syms[$urandom_range(syms.len() - 1)], 1'b0);
			end else if (pick < 75) begin
				b = 8'($urandom_range(9, 14));
				send_item((b == 8'd14) ? 8'(" ") : b, 1'b0);
			end else if (pick < 80) begin
				send_item("!", 1'b0);
				len = $urandom_range(8);
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom_range(255));
					send_item((b == "\n") ? 8'("~") : b, 1'b0);
				end
				if ($urandom_range(9) == 0)
					send_item(8'($urandom_range(255)), 1'b1);
				else
					send_item("\n", 1'b0);
			end else if (pick < 85) begin
				send_item(8'($urandom_range(255)), 1'b1);
			end else begin
				send_item(8'($urandom_range(255)), 1'b0);
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("scalar\tforeach(_9");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_text("!x\nz");
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
		send_text("!");
		send_item(8'h5A, 1'b1);
		send_text("@");

		send_random_text();
		send_item(8'h00, 1'b1);
		item_valid <= 1'b0;

		while (tracker.awaited_tokens.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("script_lexer_token_classifier_unit test passed");
		else
			$display("script_lexer_token_classifier_unit test failed");
		$finish;
	end

endmodule
